// ===== rtl/weekly_alarm_slot_table_core_assert.svh =====
// Assertion macros for the alarm slot table core.
// Included by rtl/weekly_alarm_slot_table_core.sv; expects clock and reset in scope.
`ifndef WEEKLY_ALARM_SLOT_TABLE_CORE_ASSERT_SVH
`define WEEKLY_ALARM_SLOT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define WAST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WAST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wast_pkg.sv =====
// Shared constants and codes for the alarm slot table.
// No dependencies; imported by rtl/weekly_alarm_slot_table_core.sv.
package wast_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

   localparam int KIND_W    = 3;
   localparam int SEL_W     = 6;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int WEEKDAY_W = 3;
   localparam int RPT_W     = 7;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK       = 3'd0,
      KIND_ADD        = 3'd1,
      KIND_WRITE      = 3'd2,
      KIND_DELETE     = 3'd3,
      KIND_SET_ENABLE = 3'd4,
      KIND_READ       = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_UNUSED = 2'd3
   } status_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [RPT_W-1:0]    rpt;
   } entry_type;

endpackage

// ===== rtl/weekly_alarm_slot_table_core.sv =====
// Alarm slot table core: slot storage, scan sequencer and result register.
// Depends on rtl/wast_pkg.sv and rtl/weekly_alarm_slot_table_core_assert.svh.
//
// Usage:
//  - req_* carries one command per transfer (tick, add, write, delete, set enable,
//    read). req_ready is high only while the sequencer is idle.
//  - rsp_* returns results; a tick returns one result per fired slot in ascending
//    order (or one empty result), every other command exactly one. rsp_last_item
//    marks the final result of a command.
//  - All work goes through one slot-wide compare/update path stepping one slot per
//    cycle over the slot memory (one read port, registered read data).
//  - Tick: a compare pass over every slot, a summary pass, then a scan over the slots up
//    to the highest fired one with a load for each fired slot (an empty result if none fired).
//  - Add: a free-slot search, an apply step (skipped if the table is full), a summary pass
//    and the result.
//  - Other commands: an apply step, a summary pass and the result.
//  - The result register lets the next command be taken while the last result
//    waits; if the receiver stalls, the sequencer waits before loading a new one.
//  - Reset empties the table at once (used and enable bits clear); no clearing
//    pass is needed.
`include "weekly_alarm_slot_table_core_assert.svh"

module weekly_alarm_slot_table_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [wast_pkg::KIND_W-1:0]     req_kind,
   input  logic [wast_pkg::SEL_W-1:0]      req_slot_sel,
   input  logic [wast_pkg::HOUR_W-1:0]     req_hour_in,
   input  logic [wast_pkg::MINUTE_W-1:0]   req_minute_in,
   input  logic [wast_pkg::WEEKDAY_W-1:0]  req_weekday_in,
   input  logic [wast_pkg::RPT_W-1:0]      req_repeat_in,
   input  logic                            req_enable_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_fired,
   output logic [wast_pkg::SEL_W-1:0]      rsp_entry_index,
   output logic [wast_pkg::HOUR_W-1:0]     rsp_entry_hour,
   output logic [wast_pkg::MINUTE_W-1:0]   rsp_entry_minute,
   output logic [wast_pkg::RPT_W-1:0]      rsp_entry_repeat,
   output logic                            rsp_entry_enabled,
   output logic [wast_pkg::STATUS_W-1:0]   rsp_status,
   output logic [wast_pkg::COUNT_W-1:0]    rsp_used_count,
   output logic                            rsp_next_found,
   output logic [wast_pkg::SEL_W-1:0]      rsp_next_index,
   output logic                            rsp_last_item
);
   import wast_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRE,
      ST_FIND,
      ST_APPLY,
      ST_SUM,
      ST_EMIT_SCAN,
      ST_EMIT_LOAD,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_REQ,
      SRC_MEM
   } src_type;

   typedef struct packed {
      kind_type               kind;
      logic [SEL_W-1:0]       slot_sel;
      logic [HOUR_W-1:0]      hour;
      logic [MINUTE_W-1:0]    minute;
      logic [WEEKDAY_W-1:0]   weekday;
      logic [RPT_W-1:0]       rpt;
      logic                   enable;
   } req_type;

   typedef struct packed {
      logic                   fired;
      logic [SEL_W-1:0]       index;
      entry_type              entry;
      logic                   enabled;
      status_type             status;
      logic [COUNT_W-1:0]     used_count;
      logic                   next_found;
      logic [SEL_W-1:0]       next_index;
      logic                   last;
   } rsp_type;

   localparam logic [SLOT_IDX_W-1:0] IDX_LAST = SLOT_IDX_W'(SLOT_COUNT - 1);
   localparam logic [SLOT_IDX_W-1:0] IDX_ONE  = SLOT_IDX_W'(1);

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [SLOT_IDX_W-1:0]    idx_ff, idx_in;
   logic [SLOT_IDX_W-1:0]    pipe_idx_ff, pipe_idx_in;
   logic                     pipe_vld_ff, pipe_vld_in;
   logic                     last_iss_ff, last_iss_in;
   logic [SLOT_COUNT-1:0]    used_ff, used_in;
   logic [SLOT_COUNT-1:0]    en_ff, en_in;
   logic [SLOT_COUNT-1:0]    fire_ff, fire_in;
   logic [SLOT_IDX_W-1:0]    scan_ff, scan_in;
   logic [SLOT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                     nfound_ff, nfound_in;
   logic [SLOT_IDX_W-1:0]    nidx_ff, nidx_in;
   src_type                  src_ff, src_in;
   status_type               st_ff, st_in;
   logic [SEL_W-1:0]         eidx_ff, eidx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   entry_type                slot_mem_ff [SLOT_COUNT];
   entry_type                slot_rd_ff;
   entry_type                mem_wdata;
   logic                     mem_we;

   logic                     out_free;
   logic                     in_range;
   logic [RPT_W-1:0]         wbit;
   logic                     match;
   logic [SLOT_COUNT-1:0]    fire_rest;
   kind_type                 acc_kind;

   // slot memory: one port, address is always the current slot index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[idx_ff] <= mem_wdata;
      end
      slot_rd_ff <= slot_mem_ff[idx_ff];
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_range  = {1'b0, req_ff.slot_sel} < (SEL_W + 1)'(SLOT_COUNT);
   assign wbit      = (req_ff.weekday < WEEKDAY_W'(RPT_W)) ?
                      (RPT_W'(1) << req_ff.weekday) : '0;
   assign match     = pipe_vld_ff && used_ff[pipe_idx_ff] && en_ff[pipe_idx_ff]
                      && (slot_rd_ff.hour == req_ff.hour)
                      && (slot_rd_ff.minute == req_ff.minute)
                      && ((slot_rd_ff.rpt == '0) || ((slot_rd_ff.rpt & wbit) != '0));
   assign fire_rest = fire_ff & ~(SLOT_COUNT'(1) << idx_ff);
   assign acc_kind  = kind_type'(req_kind);
   assign mem_wdata = '{hour: req_ff.hour, minute: req_ff.minute, rpt: req_ff.rpt};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      pipe_idx_in  = pipe_idx_ff;
      pipe_vld_in  = pipe_vld_ff;
      last_iss_in  = last_iss_ff;
      used_in      = used_ff;
      en_in        = en_ff;
      fire_in      = fire_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      nfound_in    = nfound_ff;
      nidx_in      = nidx_ff;
      src_in       = src_ff;
      st_in        = st_ff;
      eidx_in      = eidx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = '{kind: acc_kind, slot_sel: req_slot_sel, hour: req_hour_in,
                               minute: req_minute_in, weekday: req_weekday_in,
                               rpt: req_repeat_in, enable: req_enable_in};
               src_in      = SRC_NONE;
               st_in       = STATUS_OK;
               eidx_in     = '0;
               idx_in      = '0;
               fire_in     = '0;
               pipe_vld_in = 1'b0;
               last_iss_in = 1'b0;
               case (acc_kind)
                  KIND_TICK: begin
                     state_in = ST_FIRE;
                  end
                  KIND_ADD: begin
                     state_in = ST_FIND;
                  end
                  KIND_WRITE, KIND_DELETE, KIND_SET_ENABLE, KIND_READ: begin
                     eidx_in  = req_slot_sel;
                     idx_in   = req_slot_sel[SLOT_IDX_W-1:0];
                     state_in = ST_APPLY;
                  end
                  default: begin
                     state_in = ST_APPLY;
                  end
               endcase
            end
         end

         ST_FIRE: begin
            if (!last_iss_ff) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = idx_ff;
               if (idx_ff == IDX_LAST) begin
                  last_iss_in = 1'b1;
               end else begin
                  idx_in = idx_ff + IDX_ONE;
               end
            end else begin
               pipe_vld_in = 1'b0;
            end
            if (match) begin
               fire_in[pipe_idx_ff] = 1'b1;
               if (slot_rd_ff.rpt == '0) begin
                  en_in[pipe_idx_ff] = 1'b0;
               end
            end
            if (pipe_vld_ff && (pipe_idx_ff == IDX_LAST)) begin
               pipe_vld_in = 1'b0;
               scan_in     = '0;
               cnt_in      = '0;
               nfound_in   = 1'b0;
               nidx_in     = '0;
               state_in    = ST_SUM;
            end
         end

         ST_FIND: begin
            if (!used_ff[idx_ff]) begin
               state_in = ST_APPLY;
            end else if (idx_ff == IDX_LAST) begin
               st_in     = STATUS_FULL;
               scan_in   = '0;
               cnt_in    = '0;
               nfound_in = 1'b0;
               nidx_in   = '0;
               state_in  = ST_SUM;
            end else begin
               idx_in = idx_ff + IDX_ONE;
            end
         end

         ST_APPLY: begin
            case (req_ff.kind)
               KIND_ADD: begin
                  mem_we          = 1'b1;
                  used_in[idx_ff] = 1'b1;
                  en_in[idx_ff]   = req_ff.enable;
                  src_in          = SRC_REQ;
                  eidx_in         = SEL_W'(idx_ff);
               end
               KIND_WRITE, KIND_DELETE, KIND_SET_ENABLE, KIND_READ: begin
                  if (!in_range) begin
                     st_in = STATUS_RANGE;
                  end else if (req_ff.kind == KIND_WRITE) begin
                     mem_we          = 1'b1;
                     used_in[idx_ff] = 1'b1;
                     en_in[idx_ff]   = req_ff.enable;
                     src_in          = SRC_REQ;
                  end else if (req_ff.kind == KIND_DELETE) begin
                     used_in[idx_ff] = 1'b0;
                     en_in[idx_ff]   = 1'b0;
                  end else if (!used_ff[idx_ff]) begin
                     st_in = STATUS_UNUSED;
                  end else begin
                     if (req_ff.kind == KIND_SET_ENABLE) begin
                        en_in[idx_ff] = req_ff.enable;
                     end
                     src_in = SRC_MEM;
                  end
               end
               default: begin
               end
            endcase
            scan_in   = '0;
            cnt_in    = '0;
            nfound_in = 1'b0;
            nidx_in   = '0;
            state_in  = ST_SUM;
         end

         ST_SUM: begin
            if (used_ff[scan_ff]) begin
               cnt_in = cnt_ff + SLOT_CNT_W'(1);
               if (en_ff[scan_ff] && !nfound_ff) begin
                  nfound_in = 1'b1;
                  nidx_in   = scan_ff;
               end
            end
            if (scan_ff == IDX_LAST) begin
               if ((req_ff.kind == KIND_TICK) && (fire_ff != '0)) begin
                  idx_in   = '0;
                  state_in = ST_EMIT_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               scan_in = scan_ff + IDX_ONE;
            end
         end

         ST_EMIT_SCAN: begin
            if (fire_ff[idx_ff]) begin
               state_in = ST_EMIT_LOAD;
            end else begin
               idx_in = idx_ff + IDX_ONE;
            end
         end

         ST_EMIT_LOAD: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.fired      = 1'b1;
               rsp_in.index      = SEL_W'(idx_ff);
               rsp_in.entry      = slot_rd_ff;
               rsp_in.enabled    = en_ff[idx_ff];
               rsp_in.status     = STATUS_OK;
               rsp_in.used_count = COUNT_W'(cnt_ff);
               rsp_in.next_found = nfound_ff;
               rsp_in.next_index = SEL_W'(nidx_ff);
               rsp_in.last       = (fire_rest == '0);
               fire_in           = fire_rest;
               if (fire_rest == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_ONE;
                  state_in = ST_EMIT_SCAN;
               end
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.fired      = 1'b0;
               rsp_in.index      = eidx_ff;
               rsp_in.status     = st_ff;
               rsp_in.used_count = COUNT_W'(cnt_ff);
               rsp_in.next_found = nfound_ff;
               rsp_in.next_index = SEL_W'(nidx_ff);
               rsp_in.last       = 1'b1;
               case (src_ff)
                  SRC_REQ: begin
                     rsp_in.entry   = mem_wdata;
                     rsp_in.enabled = req_ff.enable;
                  end
                  SRC_MEM: begin
                     rsp_in.entry   = slot_rd_ff;
                     rsp_in.enabled = en_ff[idx_ff];
                  end
                  default: begin
                     rsp_in.entry   = '0;
                     rsp_in.enabled = 1'b0;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         en_ff        <= '0;
         fire_ff      <= '0;
         pipe_vld_ff  <= 1'b0;
         last_iss_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         en_ff        <= en_in;
         fire_ff      <= fire_in;
         pipe_vld_ff  <= pipe_vld_in;
         last_iss_ff  <= last_iss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      pipe_idx_ff <= pipe_idx_in;
      scan_ff     <= scan_in;
      cnt_ff      <= cnt_in;
      nfound_ff   <= nfound_in;
      nidx_ff     <= nidx_in;
      src_ff      <= src_in;
      st_ff       <= st_in;
      eidx_ff     <= eidx_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_ff.fired;
   assign rsp_entry_index   = rsp_ff.index;
   assign rsp_entry_hour    = rsp_ff.entry.hour;
   assign rsp_entry_minute  = rsp_ff.entry.minute;
   assign rsp_entry_repeat  = rsp_ff.entry.rpt;
   assign rsp_entry_enabled = rsp_ff.enabled;
   assign rsp_status        = rsp_ff.status;
   assign rsp_used_count    = rsp_ff.used_count;
   assign rsp_next_found    = rsp_ff.next_found;
   assign rsp_next_index    = rsp_ff.next_index;
   assign rsp_last_item     = rsp_ff.last;

   // a one-shot slot is reported already disabled
   `WAST_ASSERT_NOW(a_oneshot_off, rsp_valid && rsp_fired && (rsp_entry_repeat == '0),
      !rsp_entry_enabled, "fired one-shot slot still enabled")
   `WAST_ASSERT_NOW(a_count_bound, rsp_valid,
      rsp_used_count <= COUNT_W'(SLOT_COUNT), "used count above slot count")
   `WAST_ASSERT_NOW(a_fired_ok, rsp_valid && rsp_fired,
      (rsp_status == STATUS_OK) && (rsp_entry_index < SEL_W'(SLOT_COUNT)),
      "fired result with bad status or index")
   // fire bits are only set during the compare pass
   `WAST_ASSERT_NEXT(a_fire_set, state_ff != ST_FIRE,
      (fire_ff & ~$past(fire_ff)) == '0, "fire mask grew outside compare pass")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for weekly_alarm_slot_table_core: directed and random command streams,
// every result checked against an in-bench model of the alarm slot table.
// Depends on rtl/wast_pkg.sv and rtl/weekly_alarm_slot_table_core.sv.
module tb;
   import wast_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 30;
   localparam int RANDOM_ITEMS = 345;
   localparam int DRAIN_CYCLES = 60;
   localparam int REPORT_MAX   = 10;

   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
   localparam logic [RPT_W-1:0]  ONE_SHOT      = '0;
   localparam logic [RPT_W-1:0]  EVERY_DAY     = '1;

   typedef struct packed {
      logic                fired;
      logic [SEL_W-1:0]    index;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [RPT_W-1:0]    rpt;
      logic                enabled;
      status_type          status;
      logic [COUNT_W-1:0]  used_count;
      logic                next_found;
      logic [SEL_W-1:0]    next_index;
      logic                last;
   } slot_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = '0;
   logic [SEL_W-1:0]     req_slot_sel = '0;
   logic [HOUR_W-1:0]    req_hour_in = '0;
   logic [MINUTE_W-1:0]  req_minute_in = '0;
   logic [WEEKDAY_W-1:0] req_weekday_in = '0;
   logic [RPT_W-1:0]     req_repeat_in = '0;
   logic                 req_enable_in = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_fired;
   logic [SEL_W-1:0]     rsp_entry_index;
   logic [HOUR_W-1:0]    rsp_entry_hour;
   logic [MINUTE_W-1:0]  rsp_entry_minute;
   logic [RPT_W-1:0]     rsp_entry_repeat;
   logic                 rsp_entry_enabled;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_used_count;
   logic                 rsp_next_found;
   logic [SEL_W-1:0]     rsp_next_index;
   logic                 rsp_last_item;

   // model of the slot table
   logic [HOUR_W-1:0]    slot_hour   [SLOT_COUNT];
   logic [MINUTE_W-1:0]  slot_minute [SLOT_COUNT];
   logic [RPT_W-1:0]     slot_repeat [SLOT_COUNT];
   logic                 slot_enable [SLOT_COUNT];
   logic                 slot_used   [SLOT_COUNT];

   slot_report_type expected_reports[$];
   slot_report_type seen_report;
   slot_report_type due_report;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              calm = 1'b0;

   weekly_alarm_slot_table_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_slot_sel      (req_slot_sel),
      .req_hour_in       (req_hour_in),
      .req_minute_in     (req_minute_in),
      .req_weekday_in    (req_weekday_in),
      .req_repeat_in     (req_repeat_in),
      .req_enable_in     (req_enable_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fired         (rsp_fired),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entry_hour    (rsp_entry_hour),
      .rsp_entry_minute  (rsp_entry_minute),
      .rsp_entry_repeat  (rsp_entry_repeat),
      .rsp_entry_enabled (rsp_entry_enabled),
      .rsp_status        (rsp_status),
      .rsp_used_count    (rsp_used_count),
      .rsp_next_found    (rsp_next_found),
      .rsp_next_index    (rsp_next_index),
      .rsp_last_item     (rsp_last_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic slot_report_type slot_report(logic fired, logic [SEL_W-1:0] idx,
                                                   int slot, status_type st);
      slot_report_type r;
      r = '0;
      r.fired = fired;
      r.index = idx;
      r.status = st;
      if (slot >= 0) begin
         r.hour = slot_hour[slot];
         r.minute = slot_minute[slot];
         r.rpt = slot_repeat[slot];
         r.enabled = slot_enable[slot];
      end
      return r;
   endfunction

   function automatic void store_alarm(int s, logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn,
                                       logic [RPT_W-1:0] rpt, logic en);
      slot_hour[s] = hr;
      slot_minute[s] = mn;
      slot_repeat[s] = rpt;
      slot_enable[s] = en;
      slot_used[s] = 1'b1;
   endfunction

   function automatic void clear_alarm(int s);
      slot_hour[s] = '0;
      slot_minute[s] = '0;
      slot_repeat[s] = '0;
      slot_enable[s] = 1'b0;
      slot_used[s] = 1'b0;
   endfunction

   // Applies one command to the table model and queues the reports it causes.
   function automatic void predict_alarm_step(logic [KIND_W-1:0] kind, logic [SEL_W-1:0] sel,
                                              logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn,
                                              logic [WEEKDAY_W-1:0] wd, logic [RPT_W-1:0] rpt,
                                              logic en);
      slot_report_type    rows[$];
      slot_report_type    r;
      logic [RPT_W-1:0]   day_bit;
      logic [COUNT_W-1:0] used_n;
      logic               found;
      logic [SEL_W-1:0]   first_on;
      int                 s;
      int                 free_slot;
      s = int'(sel);
      day_bit = (wd < 3'd7) ? (RPT_W'(1) << wd) : '0;
      free_slot = -1;
      case (kind)
         KIND_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_used[i] && slot_enable[i] && slot_hour[i] == hr &&
                   slot_minute[i] == mn &&
                   (slot_repeat[i] == ONE_SHOT || (slot_repeat[i] & day_bit) != '0)) begin
                  if (slot_repeat[i] == ONE_SHOT) slot_enable[i] = 1'b0;
                  rows.push_back(slot_report(1'b1, SEL_W'(i), i, STATUS_OK));
               end
            end
            if (rows.size() == 0) rows.push_back(slot_report(1'b0, '0, -1, STATUS_OK));
         end
         KIND_ADD: begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
               if (!slot_used[i]) free_slot = i;
            end
            if (free_slot >= 0) begin
               store_alarm(free_slot, hr, mn, rpt, en);
               rows.push_back(slot_report(1'b0, SEL_W'(free_slot), free_slot, STATUS_OK));
            end else begin
               rows.push_back(slot_report(1'b0, '0, -1, STATUS_FULL));
            end
         end
         KIND_WRITE, KIND_DELETE, KIND_SET_ENABLE, KIND_READ: begin
            if (sel >= SLOT_COUNT) begin
               rows.push_back(slot_report(1'b0, sel, -1, STATUS_RANGE));
            end else if (kind == KIND_WRITE) begin
               store_alarm(s, hr, mn, rpt, en);
               rows.push_back(slot_report(1'b0, sel, s, STATUS_OK));
            end else if (kind == KIND_DELETE) begin
               clear_alarm(s);
               rows.push_back(slot_report(1'b0, sel, s, STATUS_OK));
            end else if (!slot_used[s]) begin
               rows.push_back(slot_report(1'b0, sel, -1, STATUS_UNUSED));
            end else begin
               if (kind == KIND_SET_ENABLE) slot_enable[s] = en;
               rows.push_back(slot_report(1'b0, sel, s, STATUS_OK));
            end
         end
         default: rows.push_back(slot_report(1'b0, '0, -1, STATUS_OK));
      endcase
      used_n = '0;
      found = 1'b0;
      first_on = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_used[i]) begin
            used_n++;
            if (slot_enable[i] && !found) begin
               found = 1'b1;
               first_on = SEL_W'(i);
            end
         end
      end
      for (int k = 0; k < rows.size(); k++) begin
         r = rows[k];
         r.used_count = used_n;
         r.next_found = found;
         r.next_index = first_on;
         r.last = (k == rows.size() - 1);
         expected_reports.push_back(r);
      end
   endfunction

   task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [SEL_W-1:0] sel,
                           input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn,
                           input logic [WEEKDAY_W-1:0] wd, input logic [RPT_W-1:0] rpt,
                           input logic en);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_slot_sel <= sel;
      req_hour_in <= hr;
      req_minute_in <= mn;
      req_weekday_in <= wd;
      req_repeat_in <= rpt;
      req_enable_in <= en;
      do @(posedge clock); while (!req_ready);
      predict_alarm_step(kind, sel, hr, mn, wd, rpt, en);
      @(negedge clock);
   endtask

   task automatic test_empty_tick();
      send_cmd(KIND_TICK, '0, '0, '0, '0, ONE_SHOT, 1'b0);
   endtask

   // all slots at 07:30; slots 0 and 4 one-shot, the rest repeat on weekday 3
   task automatic test_fill_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         send_cmd(KIND_ADD, '0, 5'd7, 6'd30, '0,
                  (i % 4 == 0) ? ONE_SHOT : (i % 4 == 1) ? EVERY_DAY : RPT_W'(8 | i), 1'b1);
      end
      send_cmd(KIND_ADD, '0, 5'd23, 6'd59, 3'd6, EVERY_DAY, 1'b1);
   endtask

   task automatic test_alarm_firing();
      send_cmd(KIND_TICK, '0, 5'd7, 6'd30, 3'd7, ONE_SHOT, 1'b0);
      send_cmd(KIND_SET_ENABLE, SEL_W'(0), '0, '0, '0, ONE_SHOT, 1'b1);
      send_cmd(KIND_SET_ENABLE, SEL_W'(4), '0, '0, '0, ONE_SHOT, 1'b1);
      send_cmd(KIND_TICK, '0, 5'd7, 6'd30, 3'd3, ONE_SHOT, 1'b0);
      send_cmd(KIND_READ, SEL_W'(0), '0, '0, '0, ONE_SHOT, 1'b0);
      send_cmd(KIND_SET_ENABLE, SEL_W'(1), '0, '0, '0, ONE_SHOT, 1'b0);
   endtask

   task automatic test_slot_edits();
      send_cmd(KIND_WRITE, SEL_W'(5), '1, '1, '1, EVERY_DAY, 1'b1);
      send_cmd(KIND_WRITE, '1, 5'd12, 6'd0, '0, EVERY_DAY, 1'b1);
      send_cmd(KIND_DELETE, SEL_W'(2), '0, '0, '0, ONE_SHOT, 1'b0);
      send_cmd(KIND_DELETE, SEL_W'(2), '0, '0, '0, ONE_SHOT, 1'b0);
      send_cmd(KIND_SET_ENABLE, SEL_W'(2), '0, '0, '0, ONE_SHOT, 1'b1);
      send_cmd(KIND_READ, SEL_W'(2), '0, '0, '0, ONE_SHOT, 1'b0);
      send_cmd(KIND_READ, SEL_W'(SLOT_COUNT), '0, '0, '0, ONE_SHOT, 1'b0);
   endtask

   task automatic test_unknown_kinds();
      send_cmd(KIND_SPARE_LO, SEL_W'(3), 5'd7, 6'd30, 3'd3, EVERY_DAY, 1'b1);
      send_cmd(KIND_SPARE_HI, '1, '1, '1, '1, EVERY_DAY, 1'b1);
   endtask

   // times mostly reuse stored alarms so ticks fire, often several slots at once
   task automatic test_random_traffic();
      int                   pick;
      int                   s;
      logic [KIND_W-1:0]    kind;
      logic [SEL_W-1:0]     sel;
      logic [HOUR_W-1:0]    hr;
      logic [MINUTE_W-1:0]  mn;
      logic [WEEKDAY_W-1:0] wd;
      logic [RPT_W-1:0]     rpt;
      logic                 en;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 120 && n < 200);
         pick = $urandom_range(0, 99);
         if (pick < 40) kind = KIND_TICK;
         else if (pick < 55) kind = KIND_ADD;
         else if (pick < 70) kind = KIND_WRITE;
         else if (pick < 80) kind = KIND_DELETE;
         else if (pick < 90) kind = KIND_SET_ENABLE;
         else if (pick < 98) kind = KIND_READ;
         else if (pick < 99) kind = KIND_SPARE_LO;
         else kind = KIND_SPARE_HI;
         if ($urandom_range(0, 99) < 85) sel = SEL_W'($urandom_range(0, SLOT_COUNT - 1));
         else sel = SEL_W'($urandom_range(0, 63));
         s = $urandom_range(0, SLOT_COUNT - 1);
         if (slot_used[s] && $urandom_range(0, 99) < 75) begin
            hr = slot_hour[s];
            mn = slot_minute[s];
         end else if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 3))
               0: begin hr = 5'd0;  mn = 6'd0;  end
               1: begin hr = 5'd23; mn = 6'd59; end
               2: begin hr = 5'd16; mn = 6'd32; end
               default: begin hr = 5'd9; mn = 6'd15; end
            endcase
         end else begin
            hr = HOUR_W'($urandom_range(0, 31));
            mn = MINUTE_W'($urandom_range(0, 63));
         end
         wd = WEEKDAY_W'($urandom_range(0, 7));
         pick = $urandom_range(0, 99);
         if (pick < 30) rpt = ONE_SHOT;
         else if (pick < 55) rpt = EVERY_DAY;
         else rpt = RPT_W'($urandom_range(1, 127));
         en = ($urandom_range(0, 99) < 80);
         send_cmd(kind, sel, hr, mn, wd, rpt, en);
      end
      calm = 1'b0;
   endtask

   function automatic string describe(slot_report_type r);
      return $sformatf({"fired=%0b index=%0d hour=%0d minute=%0d repeat=%h enabled=%0b",
                        " status=%0d used=%0d next=%0b/%0d last=%0b"},
                       r.fired, r.index, r.hour, r.minute, r.rpt, r.enabled, r.status,
                       r.used_count, r.next_found, r.next_index, r.last);
   endfunction

   task automatic note_mismatch(string what, slot_report_type exp_r, slot_report_type got_r);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("%s at cycle %0d", what, cycle_count);
         $display("  expected %s", describe(exp_r));
         $display("  actual   %s", describe(got_r));
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_report.fired = rsp_fired;
         seen_report.index = rsp_entry_index;
         seen_report.hour = rsp_entry_hour;
         seen_report.minute = rsp_entry_minute;
         seen_report.rpt = rsp_entry_repeat;
         seen_report.enabled = rsp_entry_enabled;
         seen_report.status = status_type'(rsp_status);
         seen_report.used_count = rsp_used_count;
         seen_report.next_found = rsp_next_found;
         seen_report.next_index = rsp_next_index;
         seen_report.last = rsp_last_item;
         if (expected_reports.size() == 0) begin
            note_mismatch("unexpected result transfer", '0, seen_report);
         end else begin
            due_report = expected_reports.pop_front();
            if (seen_report !== due_report) note_mismatch("result mismatch", due_report, seen_report);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("weekly_alarm_slot_table_core: mismatch");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) clear_alarm(i);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_tick();
      test_fill_table();
      test_alarm_firing();
      test_slot_edits();
      test_unknown_kinds();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("weekly_alarm_slot_table_core: match");
      end else begin
         $display("weekly_alarm_slot_table_core: mismatch");
      end
      $finish;
   end

endmodule
